>>> sv/lhist_pkg.sv
// ----------------------------------------------------------------------------
// lhist_pkg
// Shared constants for the latency histogram: bin layout, time limits,
// result status codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package lhist_pkg;

  localparam int unsigned NUM_BINS = 38;
  localparam int unsigned BIN_W    = 6;
  localparam int unsigned NUM_BOUNDS = 36;
  localparam int unsigned DUR_W    = 20;
  localparam int unsigned TS_W     = 63;
  localparam int unsigned PROD_W   = 62;

  localparam logic [BIN_W-1:0] OVF_BIN = 6'd37;

  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
  localparam logic [TS_W-1:0] LIMIT_NS = 63'd1000000;
  localparam logic [39:0] MIN_RESET = 40'd1000000000000;

  // result status codes
  localparam logic [1:0] ST_RECORDED = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_DISABLED = 2'd2;
  localparam logic [1:0] ST_READ     = 2'd3;

  // request codes
  localparam logic REQ_RECORD = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  // register index (word index of the config port)
  localparam logic REG_ENABLED = 1'b0;

  // lower edges of bins 1..36: 100 ns, 1 us, 10 us and 100 us decades
  localparam logic [DUR_W-1:0] BIN_BOUNDS [NUM_BOUNDS] = '{
    20'd100,    20'd200,    20'd300,    20'd400,    20'd500,
    20'd600,    20'd700,    20'd800,    20'd900,
    20'd1000,   20'd2000,   20'd3000,   20'd4000,   20'd5000,
    20'd6000,   20'd7000,   20'd8000,   20'd9000,
    20'd10000,  20'd20000,  20'd30000,  20'd40000,  20'd50000,
    20'd60000,  20'd70000,  20'd80000,  20'd90000,
    20'd100000, 20'd200000, 20'd300000, 20'd400000, 20'd500000,
    20'd600000, 20'd700000, 20'd800000, 20'd900000
  };

endpackage

`default_nettype wire

>>> sv/lhist_bin_map.sv
// ----------------------------------------------------------------------------
// lhist_bin_map
// Maps an in-range duration (below 1 ms) to its log-decade bin 0..36.
// ----------------------------------------------------------------------------
`default_nettype none

module lhist_bin_map (
  input  logic [lhist_pkg::DUR_W-1:0] dur,
  output logic [lhist_pkg::BIN_W-1:0] bin
);

  logic [lhist_pkg::NUM_BOUNDS-1:0] ge;
  logic [1:0]                       dec;
  logic [8:0]                       grp;
  logic [3:0]                       sub;
  logic [lhist_pkg::BIN_W-1:0]      base;

  // all edge compares in parallel
  always_comb begin
    for (int i = 0; i < lhist_pkg::NUM_BOUNDS; i++) begin
      ge[i] = (dur >= lhist_pkg::BIN_BOUNDS[i]);
    end
  end

  // decade from the 1 us, 10 us and 100 us edges
  always_comb begin
    if (ge[27]) begin
      dec = 2'd3;
    end else if (ge[18]) begin
      dec = 2'd2;
    end else if (ge[9]) begin
      dec = 2'd1;
    end else begin
      dec = 2'd0;
    end
  end

  always_comb begin
    case (dec)
      2'd0:    grp = ge[8:0];
      2'd1:    grp = ge[17:9];
      2'd2:    grp = ge[26:18];
      default: grp = ge[35:27];
    endcase
  end

  // thermometer to count within the decade
  always_comb begin
    sub = 4'd0;
    for (int j = 0; j < 9; j++) begin
      if (grp[j]) begin
        sub = 4'(j + 1);
      end
    end
  end

  assign base = {1'b0, dec, 3'b000} + {4'b0000, dec};
  assign bin  = base + {2'b00, sub};

endmodule

`default_nettype wire

>>> sv/lhist_bin_ram.sv
// ----------------------------------------------------------------------------
// lhist_bin_ram
// Bin count memory, one write and one registered read port; entries not
// written since reset read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module lhist_bin_ram #(
  parameter int CNT_W = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [lhist_pkg::BIN_W-1:0] wr_addr,
  input  logic [CNT_W-1:0]            wr_data,
  input  logic                        rd_en,
  input  logic [lhist_pkg::BIN_W-1:0] rd_addr,
  output logic [CNT_W-1:0]            rd_data
);

  logic [CNT_W-1:0]              mem [lhist_pkg::NUM_BINS];
  logic [lhist_pkg::NUM_BINS-1:0] valid_r;
  logic [CNT_W-1:0]              rd_q_r;
  logic                          rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_q_r : '0;

endmodule

`default_nettype wire

>>> sv/latency_log_histogram.sv
// sequence: an enabled record steps through multiply, add, compare, bin read and write back;
//   a read or a record taken while disabled goes straight to bin read and write back
// items: one in flight; busy stays high through write back, and the result strobe is registered from it
// reset: synchronous active-low rst_n clears control, stats, enable and the
//   bin memory valid bits at once (no clearing pass); results cannot be stalled
// ----------------------------------------------------------------------------
// latency_log_histogram
// Latency monitor: converts start/end timestamps to an interval, keeps
// count, sum, min and max, and counts it in a log-decade histogram.
// ----------------------------------------------------------------------------
`default_nettype none

module latency_log_histogram #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [31:0] in_start_sec,
  input  logic [29:0] in_start_nsec,
  input  logic [31:0] in_end_sec,
  input  logic [29:0] in_end_nsec,
  input  logic [5:0]  in_bin_select,
  // result channel
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [5:0]  out_bin_used,
  output logic [31:0] out_bin_count,
  output logic [31:0] out_call_count,
  output logic [63:0] out_sum_ns,
  output logic [39:0] out_min_ns,
  output logic [19:0] out_max_ns,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DW = lhist_pkg::DUR_W;
  localparam int BW = lhist_pkg::BIN_W;
  localparam int TW = lhist_pkg::TS_W;
  localparam int PW = lhist_pkg::PROD_W;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_BIN  = 3'd4;
  localparam logic [2:0] S_RD   = 3'd5;

  logic [2:0] state_r, state_nxt;

  // captured command
  logic          req_r;
  logic [31:0]   ssec_r, esec_r;
  logic [29:0]   snsec_r, ensec_r;
  logic [BW-1:0] sel_r;

  // time conversion pipeline
  logic [PW-1:0] prod_s_r, prod_e_r;
  logic [TW-1:0] ts_s_r, ts_e_r;
  logic [TW:0]   diff;
  logic [DW-1:0] dur_r;
  logic          ovf_r;

  // per-item decision
  logic [BW-1:0] bin_r, bin_nxt, map_bin, sel_clamp;
  logic [1:0]    status_r, status_nxt;

  // statistics
  logic                   enabled_r;
  logic [COUNT_WIDTH-1:0] calls_r;
  logic [63:0]            total_r;
  logic [39:0]            min_r;
  logic [DW-1:0]          max_r;

  // memory interface
  logic                   rd_en, wr_en;
  logic [COUNT_WIDTH-1:0] cnt_cur, cnt_inc;
  logic [64:0]            total_sum;

  // result registers
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [BW-1:0] out_bin_r;
  logic [31:0]   out_count_r, out_count_nxt;
  logic [COUNT_WIDTH+31:0] cnt_ext, calls_ext;

  logic in_fire, cfg_wr, is_rec;

  assign in_fire = start && !busy;
  assign busy    = (state_r != S_IDLE);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign prdata  = (paddr[2] == lhist_pkg::REG_ENABLED) ? {31'b0, enabled_r} : 32'b0;

  // --------------------------------------------------------------------------
  // sequencer: records run the full conversion; reads and disabled records
  // go straight to the bin stage
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_req_type == lhist_pkg::REQ_READ || !enabled_r) begin
            state_nxt = S_BIN;
          end else begin
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL:   state_nxt = S_ADD;
      S_ADD:   state_nxt = S_CMP;
      S_CMP:   state_nxt = S_BIN;
      S_BIN:   state_nxt = S_RD;
      S_RD:    state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // command capture and timestamp arithmetic
  // ts = sec * 1e9 + nsec fits in 63 bits for any field pattern
  // --------------------------------------------------------------------------
  assign diff = {1'b0, ts_e_r} - {1'b0, ts_s_r};

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r   <= in_req_type;
      ssec_r  <= in_start_sec;
      snsec_r <= in_start_nsec;
      esec_r  <= in_end_sec;
      ensec_r <= in_end_nsec;
      sel_r   <= in_bin_select;
    end
    if (state_r == S_MUL) begin
      prod_s_r <= PW'(ssec_r) * PW'(lhist_pkg::NS_PER_SEC);
      prod_e_r <= PW'(esec_r) * PW'(lhist_pkg::NS_PER_SEC);
    end
    if (state_r == S_ADD) begin
      ts_s_r <= TW'(prod_s_r) + TW'(snsec_r);
      ts_e_r <= TW'(prod_e_r) + TW'(ensec_r);
    end
    if (state_r == S_CMP) begin
      // a borrow means the start is later than the end
      ovf_r <= diff[TW] || (diff[TW-1:0] >= lhist_pkg::LIMIT_NS);
      dur_r <= diff[DW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // bin stage: pick the bin and issue the memory read
  // --------------------------------------------------------------------------
  lhist_bin_map u_bin_map (
    .dur (dur_r),
    .bin (map_bin)
  );

  assign sel_clamp = (sel_r > lhist_pkg::OVF_BIN) ? lhist_pkg::OVF_BIN : sel_r;

  always_comb begin
    if (req_r == lhist_pkg::REQ_READ) begin
      status_nxt = lhist_pkg::ST_READ;
      bin_nxt    = sel_clamp;
    end else if (!enabled_r) begin
      status_nxt = lhist_pkg::ST_DISABLED;
      bin_nxt    = '0;
    end else if (ovf_r) begin
      status_nxt = lhist_pkg::ST_OVERFLOW;
      bin_nxt    = lhist_pkg::OVF_BIN;
    end else begin
      status_nxt = lhist_pkg::ST_RECORDED;
      bin_nxt    = map_bin;
    end
  end

  assign rd_en = (state_r == S_BIN);

  always_ff @(posedge clk) begin
    if (state_r == S_BIN) begin
      status_r <= status_nxt;
      bin_r    <= bin_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // read-modify-write of the bin count; one item in flight, so no forwarding
  // --------------------------------------------------------------------------
  assign cnt_inc = (cnt_cur == {COUNT_WIDTH{1'b1}}) ? cnt_cur : cnt_cur + 1'b1;
  assign wr_en   = (state_r == S_RD) &&
                   (status_r == lhist_pkg::ST_RECORDED || status_r == lhist_pkg::ST_OVERFLOW);
  assign is_rec  = (state_r == S_RD) && (status_r == lhist_pkg::ST_RECORDED);

  lhist_bin_ram #(
    .CNT_W (COUNT_WIDTH)
  ) u_bin_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (bin_r),
    .wr_data (cnt_inc),
    .rd_en   (rd_en),
    .rd_addr (bin_nxt),
    .rd_data (cnt_cur)
  );

  // result count, low 32 bits of the counter
  always_comb begin
    case (status_r)
      lhist_pkg::ST_READ:     cnt_ext = {32'b0, cnt_cur};
      lhist_pkg::ST_DISABLED: cnt_ext = '0;
      default:                cnt_ext = {32'b0, cnt_inc};
    endcase
    out_count_nxt = cnt_ext[31:0];
  end

  // --------------------------------------------------------------------------
  // running statistics, updated only by in-range records
  // --------------------------------------------------------------------------
  assign total_sum = {1'b0, total_r} + {45'b0, dur_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
      calls_r   <= '0;
      total_r   <= '0;
      min_r     <= lhist_pkg::MIN_RESET;
      max_r     <= '0;
    end else begin
      if (cfg_wr && paddr[2] == lhist_pkg::REG_ENABLED) begin
        enabled_r <= pwdata[0];
      end
      if (is_rec) begin
        if (calls_r != {COUNT_WIDTH{1'b1}}) begin
          calls_r <= calls_r + 1'b1;
        end
        // sum saturates at all ones
        total_r <= total_sum[64] ? {64{1'b1}} : total_sum[63:0];
        if ({20'b0, dur_r} < min_r) begin
          min_r <= {20'b0, dur_r};
        end
        if (dur_r > max_r) begin
          max_r <= dur_r;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // result transfer: one-cycle strobe; stats ports show the state after it
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_RD);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RD) begin
      out_status_r <= status_r;
      out_bin_r    <= bin_r;
      out_count_r  <= out_count_nxt;
    end
  end

  assign calls_ext = {32'b0, calls_r};

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_bin_used   = out_bin_r;
  assign out_bin_count  = out_count_r;
  assign out_call_count = calls_ext[31:0];
  assign out_sum_ns     = total_r;
  assign out_min_ns     = min_r;
  assign out_max_ns     = max_r;

endmodule

`default_nettype wire

>>> sim/lhist_checker.sv
// ----------------------------------------------------------------------------
// lhist_checker
// Watches the command, result and config channels of the latency histogram,
// keeps its own copy of the statistics and compares every result transfer.
// ----------------------------------------------------------------------------
module lhist_checker
  import lhist_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_req_type,
  input  logic [31:0] in_start_sec,
  input  logic [29:0] in_start_nsec,
  input  logic [31:0] in_end_sec,
  input  logic [29:0] in_end_nsec,
  input  logic [5:0]  in_bin_select,
  input  logic        out_valid,
  input  logic [1:0]  out_status,
  input  logic [5:0]  out_bin_used,
  input  logic [31:0] out_bin_count,
  input  logic [31:0] out_call_count,
  input  logic [63:0] out_sum_ns,
  input  logic [39:0] out_min_ns,
  input  logic [19:0] out_max_ns,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  input  logic        run_done,
  output int          outstanding,
  output int          fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]  ENABLED_ADDR = 3'(REG_ENABLED) << 2;
  localparam logic [63:0] COUNT_MAX    = {64{1'b1}} >> (64 - COUNT_WIDTH);

  typedef struct {
    logic [1:0]  status;
    logic [5:0]  bin_used;
    logic [31:0] bin_count;
    logic [31:0] call_count;
    logic [63:0] sum_ns;
    logic [39:0] min_ns;
    logic [19:0] max_ns;
  } lat_result_t;

  lat_result_t expected_results[$];

  logic [63:0] bin_tally [NUM_BINS];
  logic [63:0] calls_seen;
  logic [63:0] total_ns_seen;
  logic [39:0] shortest_seen;
  logic [19:0] longest_seen;
  logic        enable_bit;
  int          errors;
  int          result_idx;
  bit          leftovers_reported;

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    errors++;
    if (errors <= 40)
      $display("%0t ns: result %0d %s mismatch: got %0h, expected %0h",
               $realtime, result_idx, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) flag_mismatch(what, got, want);
  endtask

  // log-decade bin of an in-range interval
  function automatic logic [5:0] decade_bin(input logic [19:0] d);
    if (d < 20'd1000)   return 6'(d / 20'd100);
    if (d < 20'd10000)  return 6'(9 + d / 20'd1000);
    if (d < 20'd100000) return 6'(18 + d / 20'd10000);
    return 6'(27 + d / 20'd100000);
  endfunction

  function automatic logic [63:0] sat_inc(input logic [63:0] v);
    return (v >= COUNT_MAX) ? COUNT_MAX : v + 64'd1;
  endfunction

  task automatic predict_latency_result(output lat_result_t r);
    logic [63:0] t_start, t_end, d;
    logic [5:0]  b;
    r.bin_used  = '0;
    r.bin_count = '0;
    if (in_req_type == REQ_READ) begin
      b = (in_bin_select > OVF_BIN) ? OVF_BIN : in_bin_select;
      r.status    = ST_READ;
      r.bin_used  = b;
      r.bin_count = bin_tally[b][31:0];
    end else if (!enable_bit) begin
      r.status = ST_DISABLED;
    end else begin
      t_start = 64'(in_start_sec) * 64'(NS_PER_SEC) + 64'(in_start_nsec);
      t_end   = 64'(in_end_sec) * 64'(NS_PER_SEC) + 64'(in_end_nsec);
      if (t_start > t_end || t_end - t_start >= 64'(LIMIT_NS)) begin
        b        = OVF_BIN;
        r.status = ST_OVERFLOW;
      end else begin
        d        = t_end - t_start;
        b        = decade_bin(d[19:0]);
        r.status = ST_RECORDED;
        calls_seen = sat_inc(calls_seen);
        total_ns_seen = (total_ns_seen > ~64'd0 - d) ? ~64'd0 : total_ns_seen + d;
        if (d[19:0] > longest_seen) longest_seen = d[19:0];
        if (64'(shortest_seen) > d) shortest_seen = d[39:0];
      end
      bin_tally[b] = sat_inc(bin_tally[b]);
      r.bin_used   = b;
      r.bin_count  = bin_tally[b][31:0];
    end
    r.call_count = calls_seen[31:0];
    r.sum_ns     = total_ns_seen;
    r.min_ns     = shortest_seen;
    r.max_ns     = longest_seen;
  endtask

  always @(posedge clk) begin
    lat_result_t want;
    lat_result_t fresh;
    if (!rst_n) begin
      foreach (bin_tally[i]) bin_tally[i] = '0;
      calls_seen    = '0;
      total_ns_seen = '0;
      shortest_seen = MIN_RESET;
      longest_seen  = '0;
      enable_bit    = 1'b0;
      expected_results.delete();
    end else begin
      if (psel && penable && pready && paddr == ENABLED_ADDR) begin
        if (pwrite) enable_bit = pwdata[0];
        else check_field("enabled readback", 64'(prdata[0]), 64'(enable_bit));
      end
      if (out_valid === 1'b1) begin
        if (expected_results.size() == 0) begin
          flag_mismatch("unexpected transfer", 64'(out_status), '0);
        end else begin
          want = expected_results.pop_front();
          check_field("status", 64'(out_status), 64'(want.status));
          check_field("bin_used", 64'(out_bin_used), 64'(want.bin_used));
          check_field("bin_count", 64'(out_bin_count), 64'(want.bin_count));
          check_field("call_count", 64'(out_call_count), 64'(want.call_count));
          check_field("sum_ns", out_sum_ns, want.sum_ns);
          check_field("min_ns", 64'(out_min_ns), 64'(want.min_ns));
          check_field("max_ns", 64'(out_max_ns), 64'(want.max_ns));
        end
        result_idx++;
      end
      if (start && busy === 1'b0) begin
        predict_latency_result(fresh);
        expected_results.push_back(fresh);
      end
      if (run_done && !leftovers_reported) begin
        leftovers_reported = 1'b1;
        foreach (expected_results[i])
          flag_mismatch("missing transfer", '0, 64'(expected_results[i].status));
      end
    end
    outstanding <= expected_results.size();
    fail_count  <= errors;
  end

endmodule

>>> sim/tb_latency_log_histogram.sv
// ----------------------------------------------------------------------------
// tb_latency_log_histogram
// Drives directed and random interval records and bin reads into the latency
// histogram, switches the enable register between phases, and takes the
// verdict from the checker that predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_latency_log_histogram;
  import lhist_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          COUNT_WIDTH    = 32;
  localparam int          WATCHDOG_LIMIT = 3000;
  localparam int          DRAIN_CYCLES   = 12;    // extra wait once the last result has drained
  localparam logic [2:0]  ENABLED_ADDR   = 3'(REG_ENABLED) << 2;
  localparam logic [31:0] SEC_MAX        = 32'hFFFF_FFFF;
  localparam logic [29:0] NSEC_ALL_ONES  = 30'h3FFF_FFFF;
  localparam logic [29:0] NSEC_TOP       = 30'd999_999_999;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_req_type = REQ_RECORD;
  logic [31:0] in_start_sec = '0;
  logic [29:0] in_start_nsec = '0;
  logic [31:0] in_end_sec = '0;
  logic [29:0] in_end_nsec = '0;
  logic [5:0]  in_bin_select = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [5:0]  out_bin_used;
  logic [31:0] out_bin_count;
  logic [31:0] out_call_count;
  logic [63:0] out_sum_ns;
  logic [39:0] out_min_ns;
  logic [19:0] out_max_ns;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        run_done = 1'b0;
  int          outstanding;
  int          fail_count;

  bit          steady = 1'b0;     // no idling while set
  int          idle_cycles = 0;

  always #5 clk = ~clk;

  latency_log_histogram #(.COUNT_WIDTH(COUNT_WIDTH)) i_dut (.*);

  lhist_checker #(.COUNT_WIDTH(COUNT_WIDTH)) i_checker (.*);

  // ends the run when no transfer of any kind happens for too long
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1 || (psel && penable && pready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // mostly short gaps, a few long ones, and stretches with none at all
  function automatic int idle_gap();
    int r;
    if ($urandom_range(0, 39) == 0) steady = ~steady;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // one command transfer, start held until busy is seen low at an edge
  task automatic issue_item(input logic req, input logic [31:0] ss,
                            input logic [29:0] sn, input logic [31:0] es,
                            input logic [29:0] en, input logic [5:0] sel);
    int gap;
    start         <= 1'b1;
    in_req_type   <= req;
    in_start_sec  <= ss;
    in_start_nsec <= sn;
    in_end_sec    <= es;
    in_end_nsec   <= en;
    in_bin_select <= sel;
    do @(posedge clk); while (busy !== 1'b0);
    gap = idle_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // read with junk in the timestamp fields, they must not matter
  task automatic read_bin(input logic [5:0] sel);
    issue_item(REQ_READ, $urandom, 30'($urandom), $urandom, 30'($urandom), sel);
  endtask

  // record an interval of dur ns from the given start; reversed swaps the
  // two timestamps so the interval comes out negative
  task automatic record_span(input logic [31:0] ss, input logic [29:0] sn,
                             input logic [63:0] dur, input bit reversed);
    logic [63:0] stop_ns;
    logic [31:0] es;
    logic [29:0] en;
    stop_ns = 64'(ss) * 64'(NS_PER_SEC) + 64'(sn) + dur;
    if (stop_ns / 64'(NS_PER_SEC) > 64'(SEC_MAX)) begin
      ss      = ss - 32'd1;
      stop_ns = stop_ns - 64'(NS_PER_SEC);
    end
    es = 32'(stop_ns / 64'(NS_PER_SEC));
    en = 30'(stop_ns % 64'(NS_PER_SEC));
    // sometimes carry a second into the nanosecond field
    if ($urandom_range(0, 3) == 0 && en < NSEC_ALL_ONES - NSEC_TOP && es != '0) begin
      es = es - 32'd1;
      en = en + NS_PER_SEC;
    end
    if (reversed) issue_item(REQ_RECORD, es, en, ss, sn, 6'($urandom));
    else          issue_item(REQ_RECORD, ss, sn, es, en, 6'($urandom));
  endtask

  // register write and read-back once the block has drained
  task automatic write_enable(input logic val);
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || busy !== 1'b0);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ENABLED_ADDR;
    pwdata  <= {31'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic random_item();
    int          r;
    int          decade;
    logic [63:0] step;
    logic [63:0] dur;
    logic [31:0] ss;
    logic [29:0] sn;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      if ($urandom_range(0, 4) != 0) read_bin(6'($urandom_range(0, 37)));
      else read_bin(6'($urandom_range(38, 63)));
    end else if (r < 22) begin
      // noise: raw fields, mostly overflow or negative
      issue_item(REQ_RECORD, $urandom, 30'($urandom), $urandom, 30'($urandom),
                 6'($urandom));
    end else begin
      case ($urandom_range(0, 9))
        0:       ss = '0;
        1:       ss = SEC_MAX;
        default: ss = $urandom;
      endcase
      if ($urandom_range(0, 6) != 0) sn = 30'($urandom_range(0, NSEC_TOP));
      else sn = 30'($urandom_range(0, NSEC_ALL_ONES));
      decade = $urandom_range(0, 3);
      step   = 64'd100;
      repeat (decade) step = step * 64'd10;
      if (r < 28)
        record_span(ss, sn, 64'($urandom_range(1, 2_000_000)), 1'b1);
      else if (r < 34)
        record_span(ss, sn, 64'($urandom_range(1_000_000, 3_000_000)), 1'b0);
      else if (r < 48) begin
        // bin edges and one below them
        dur = step * 64'($urandom_range(1, 10)) - 64'($urandom_range(0, 1));
        record_span(ss, sn, dur, 1'b0);
      end else
        record_span(ss, sn, 64'($urandom_range(0, 32'(step * 64'd10 - 64'd1))), 1'b0);
    end
  endtask

  initial begin
    logic settings [5];
    int   lengths [5];
    int   span_list [10];
    settings  = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
    lengths   = '{200, 200, 50, 200, 175};
    span_list = '{99, 100, 999, 1000, 9999, 10000, 99999, 100000, 999999, 1000000};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // after reset the block rejects records
    record_span(32'd3, 30'd0, 64'd500, 1'b0);
    read_bin(6'd0);
    read_bin(6'd63);

    write_enable(1'b1);
    // zero intervals, including all-ones timestamps
    record_span(32'd0, 30'd0, 64'd0, 1'b0);
    issue_item(REQ_RECORD, SEC_MAX, NSEC_ALL_ONES, SEC_MAX, NSEC_ALL_ONES, 6'd63);
    // decade edges up to the last in-range value, then the limit itself
    foreach (span_list[i])
      record_span($urandom, 30'($urandom_range(0, NSEC_TOP)), 64'(span_list[i]), 1'b0);
    // end one ns before start
    issue_item(REQ_RECORD, 32'd5, 30'd10, 32'd5, 30'd9, 6'd0);
    // start nanoseconds past one second, a 2 ns interval
    issue_item(REQ_RECORD, 32'd7, NSEC_ALL_ONES, 32'd8, NSEC_ALL_ONES - NSEC_TOP + 30'd1, 6'd0);
    issue_item(REQ_RECORD, SEC_MAX, 30'd0, SEC_MAX, NSEC_TOP, 6'd0);
    issue_item(REQ_RECORD, SEC_MAX, 30'd999_000_000, SEC_MAX, NSEC_TOP, 6'd0);
    issue_item(REQ_RECORD, SEC_MAX, NSEC_ALL_ONES, 32'd0, 30'd0, 6'd0);
    read_bin(6'd36);
    read_bin(6'd37);
    read_bin(6'd38);
    write_enable(1'b0);
    record_span(32'd9, 30'd0, 64'd250, 1'b0);

    foreach (settings[p]) begin
      write_enable(settings[p]);
      repeat (lengths[p]) random_item();
    end

    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || busy !== 1'b0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    run_done <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
